// ===== sv/priority_handler_chain_manager_core_assert.svh =====
// assertion macros for the chain manager checker
`ifndef PRIORITY_HANDLER_CHAIN_MANAGER_CORE_ASSERT_SVH
`define PRIORITY_HANDLER_CHAIN_MANAGER_CORE_ASSERT_SVH

// property checked on every clock edge out of reset
`define PHCM_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("phcm assertion failed");

// condition that must never hold
`define PHCM_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("phcm forbidden condition seen");

`endif

// ===== sv/phcm_pkg.sv =====
`default_nettype none
package phcm_pkg;

	typedef enum logic [1:0] {
		CMD_REG     = 2'd0,
		CMD_REG_DEF = 2'd1,
		CMD_REL     = 2'd2,
		CMD_REL_DEF = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_CAUSE = 3'd1,
		ST_LINKED    = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	localparam logic CFG_STOP_CODE  = 1'b0;
	localparam logic CFG_TABLE_BASE = 1'b1;

	localparam logic [31:0] STOP_CODE_RST  = 32'h0000_0000;
	localparam logic [31:0] TABLE_BASE_RST = 32'h0000_0440;
	localparam logic [31:0] CODE_OFFSET    = 32'd8;

	// both short queues hold two entries
	localparam int QDEPTH = 2;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  cause;
		logic [1:0]  prio;
		logic [31:0] handler;
		logic [31:0] link;
		status_t     status;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic        wv;
		logic [31:0] addr;
		logic [31:0] data;
		logic        last;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_WAIT,
		S_FAIL,
		S_FREE,
		S_WALK,
		S_WCHK,
		S_INS_NEW,
		S_INS_PREV,
		S_RWALK,
		S_RCHK,
		S_UNLINK,
		S_RFREE,
		S_LEAD,
		S_T_START,
		S_T_ISSUE,
		S_T_EMIT,
		S_L_START,
		S_L_H,
		S_L_HX,
		S_L_END,
		S_FINISH
	} state_t;

endpackage
`default_nettype wire

// ===== sv/phcm_front.sv =====
`default_nettype none
module phcm_front #(
	parameter int CAUSE_COUNT = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [1:0]        cmd,
	input  wire logic [7:0]        cause,
	input  wire logic [1:0]        priority_req,
	input  wire logic [31:0]       handler_addr,
	input  wire logic [31:0]       link_word,
	output logic                   req_valid,
	output phcm_pkg::req_t         req,
	input  wire logic              req_take
);
	import phcm_pkg::*;

	req_t        cls;
	logic        bad;
	logic        wr_en;
	logic        rd_en;
	req_t        fq_q [QDEPTH];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;

	// stateless checks
	always_comb begin
		bad = {1'b0, cause} >= 9'(CAUSE_COUNT);
		cls.cmd = cmd_t'(cmd);
		cls.cause = cause;
		cls.prio = priority_req;
		cls.handler = handler_addr;
		cls.link = link_word;
		cls.status = ST_OK;
		unique case (cmd_t'(cmd))
			CMD_REG: begin
				if (bad) begin
					cls.status = ST_BAD_CAUSE;
				end else if (link_word != 32'd0) begin
					cls.status = ST_LINKED;
				end
			end
			CMD_REG_DEF: begin
				if (link_word != 32'd0) begin
					cls.status = ST_LINKED;
				end
			end
			CMD_REL: begin
				if (bad) begin
					cls.status = ST_BAD_CAUSE;
				end
			end
			CMD_REL_DEF: begin
				cls.status = ST_OK;
			end
		endcase
	end

	assign full = cnt_q == 2'(QDEPTH);
	assign req_valid = cnt_q != 2'd0;
	assign req = fq_q[rp_q];
	assign wr_en = push && !full;
	assign rd_en = req_take && req_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fq_q[wp_q] <= cls;
		end
	end

endmodule
`default_nettype wire

// ===== sv/phcm_back.sv =====
`default_nettype none
module phcm_back #(
	parameter int CAUSE_COUNT = 16,
	parameter int NODE_COUNT  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire phcm_pkg::req_t    req,
	output logic                   req_take,
	input  wire logic [31:0]       stop_code,
	input  wire logic [31:0]       tbl_base,
	output logic                   empty,
	input  wire logic              pop,
	output phcm_pkg::res_t         res
);
	import phcm_pkg::*;

	localparam int AW = $clog2(NODE_COUNT);
	localparam int NW = $clog2(NODE_COUNT + 1);
	localparam int CW = (CAUSE_COUNT > 1) ? $clog2(CAUSE_COUNT) : 1;
	localparam logic [NW-1:0] NIL = NW'(NODE_COUNT);
	localparam logic [CW-1:0] C_LAST = CW'(CAUSE_COUNT - 1);

	state_t          state_q, state_d, ret_q;
	req_t            r_q;
	logic [NW-1:0]   free_q;
	logic [NW-1:0]   head_q [CAUSE_COUNT];
	logic [31:0]     dflt_q;
	logic            dflt_vld_q;
	logic [NW-1:0]   cur_q, prev_q, new_q, nx_q;
	logic [CW-1:0]   c_q;
	logic [31:0]     cur_h_q;
	logic [AW-1:0]   ra_q;
	logic [31:0]     rd_h_q;
	logic [1:0]      rd_p_q;
	logic [NW-1:0]   rd_l_q;

	logic [31:0]     h_mem [NODE_COUNT];
	logic [1:0]      p_mem [NODE_COUNT];
	logic [NW-1:0]   l_mem [NODE_COUNT];
	logic            l_vld_q [NODE_COUNT];

	res_t            pend_q;
	logic            pend_vld_q;
	res_t            of_q [QDEPTH];
	logic            of_wp_q, of_rp_q;
	logic [1:0]      of_cnt_q;

	logic [31:0]     ft;
	logic [CW-1:0]   ci;
	logic            of_full;
	logic            room;
	logic            head_c_nil;
	logic            rd_nil;
	logic            em_en;
	res_t            em;
	logic            fin_en;
	logic            lw_en;
	logic [NW-1:0]   lw_addr;
	logic [NW-1:0]   lw_data;
	logic            hw_en;
	logic            push_en;
	res_t            push_d;
	logic            pop_en;

	assign ft = dflt_vld_q ? dflt_q + CODE_OFFSET : stop_code;
	assign ci = r_q.cause[CW-1:0];
	assign of_full = of_cnt_q == 2'(QDEPTH);
	assign room = !pend_vld_q || !of_full;
	assign head_c_nil = head_q[c_q] == NIL;
	assign rd_nil = rd_l_q == NIL;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (r_q.status != ST_OK) begin
					state_d = S_FAIL;
				end else begin
					unique case (r_q.cmd)
						CMD_REG: state_d = (free_q == NIL) ? S_FAIL : S_WAIT;
						CMD_REG_DEF: state_d = S_LEAD;
						CMD_REL: state_d = S_RWALK;
						CMD_REL_DEF: begin
							if (!dflt_vld_q || dflt_q != r_q.handler) begin
								state_d = S_FAIL;
							end else begin
								state_d = S_LEAD;
							end
						end
					endcase
				end
			end
			S_WAIT: state_d = ret_q;
			S_FAIL: state_d = S_FINISH;
			S_FREE: state_d = S_WALK;
			S_WALK: state_d = (cur_q == NIL) ? S_INS_NEW : S_WAIT;
			S_WCHK: state_d = (rd_p_q >= r_q.prio) ? S_WALK : S_INS_NEW;
			S_INS_NEW: state_d = S_INS_PREV;
			S_INS_PREV: state_d = S_T_START;
			S_RWALK: state_d = (cur_q == NIL) ? S_FAIL : S_WAIT;
			S_RCHK: state_d = (rd_h_q == r_q.handler) ? S_UNLINK : S_RWALK;
			S_UNLINK: state_d = S_RFREE;
			S_RFREE: state_d = S_LEAD;
			S_LEAD: begin
				if (room) begin
					state_d = S_T_START;
				end
			end
			S_T_START: state_d = S_T_ISSUE;
			S_T_ISSUE: state_d = head_c_nil ? S_T_EMIT : S_WAIT;
			S_T_EMIT: begin
				if (room) begin
					state_d = (c_q == C_LAST) ? S_L_START : S_T_ISSUE;
				end
			end
			S_L_START: begin
				if (!head_c_nil) begin
					state_d = S_WAIT;
				end else if (c_q == C_LAST) begin
					state_d = S_FINISH;
				end
			end
			S_L_H: state_d = rd_nil ? S_L_END : S_WAIT;
			S_L_HX: begin
				if (room) begin
					state_d = rd_nil ? S_L_END : S_WAIT;
				end
			end
			S_L_END: begin
				if (room) begin
					state_d = (c_q == C_LAST) ? S_FINISH : S_L_START;
				end
			end
			S_FINISH: begin
				if (!of_full) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_take = 1'b0;
		em_en = 1'b0;
		em = '{status: ST_OK, wv: 1'b1, addr: 32'd0, data: 32'd0, last: 1'b0};
		fin_en = 1'b0;
		lw_en = 1'b0;
		lw_addr = prev_q;
		lw_data = new_q;
		hw_en = 1'b0;
		unique case (state_q)
			S_IDLE: req_take = req_valid;
			S_FAIL: begin
				em_en = 1'b1;
				em.status = r_q.status;
				em.wv = 1'b0;
			end
			S_FREE: hw_en = 1'b1;
			S_INS_NEW: begin
				lw_en = 1'b1;
				lw_addr = new_q;
				lw_data = cur_q;
			end
			S_INS_PREV: lw_en = prev_q != NIL;
			S_UNLINK: begin
				lw_en = prev_q != NIL;
				lw_data = nx_q;
			end
			S_RFREE: begin
				lw_en = 1'b1;
				lw_addr = cur_q;
				lw_data = free_q;
			end
			S_LEAD: begin
				em_en = room;
				em.addr = r_q.handler;
				em.data = (r_q.cmd == CMD_REG_DEF) ? ft : 32'd0;
			end
			S_T_EMIT: begin
				em_en = room;
				em.addr = tbl_base + {{(30 - CW){1'b0}}, c_q, 2'b00};
				em.data = head_c_nil ? ft : rd_h_q + CODE_OFFSET;
			end
			S_L_HX: begin
				em_en = room;
				em.addr = cur_h_q;
				em.data = rd_h_q + CODE_OFFSET;
			end
			S_L_END: begin
				em_en = room;
				em.addr = cur_h_q;
				em.data = ft;
			end
			S_FINISH: fin_en = !of_full;
			default: begin
				em_en = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			free_q <= '0;
			for (int i = 0; i < CAUSE_COUNT; i++) begin
				head_q[i] <= NIL;
			end
			for (int i = 0; i < NODE_COUNT; i++) begin
				l_vld_q[i] <= 1'b0;
			end
			dflt_q <= 32'd0;
			dflt_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (lw_en) begin
				l_vld_q[lw_addr[AW-1:0]] <= 1'b1;
			end
			if (em_en) begin
				pend_vld_q <= 1'b1;
			end else if (fin_en) begin
				pend_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_DISP: begin
					if (r_q.status == ST_OK && r_q.cmd == CMD_REG && free_q != NIL) begin
						ret_q <= S_FREE;
					end
				end
				S_FREE: free_q <= rd_l_q;
				S_WALK: ret_q <= S_WCHK;
				S_INS_PREV: begin
					if (prev_q == NIL) begin
						head_q[ci] <= new_q;
					end
				end
				S_RWALK: ret_q <= S_RCHK;
				S_UNLINK: begin
					if (prev_q == NIL) begin
						head_q[ci] <= nx_q;
					end
				end
				S_RFREE: free_q <= cur_q;
				S_LEAD: begin
					if (room) begin
						if (r_q.cmd == CMD_REG_DEF) begin
							dflt_q <= r_q.handler;
							dflt_vld_q <= 1'b1;
						end else if (r_q.cmd == CMD_REL_DEF) begin
							if (r_q.link == stop_code) begin
								dflt_q <= 32'd0;
								dflt_vld_q <= 1'b0;
							end else begin
								dflt_q <= r_q.link - CODE_OFFSET;
							end
						end
					end
				end
				S_T_ISSUE: ret_q <= S_T_EMIT;
				S_L_START: ret_q <= S_L_H;
				S_L_H: ret_q <= S_L_HX;
				S_L_HX: ret_q <= S_L_HX;
				default: begin
					ret_q <= ret_q;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					r_q <= req;
				end
			end
			S_DISP: begin
				if (r_q.status == ST_OK) begin
					unique case (r_q.cmd)
						CMD_REG: begin
							if (free_q == NIL) begin
								r_q.status <= ST_EMPTY;
							end else begin
								new_q <= free_q;
								ra_q <= free_q[AW-1:0];
							end
						end
						CMD_REL: begin
							cur_q <= head_q[ci];
							prev_q <= NIL;
						end
						CMD_REL_DEF: begin
							if (!dflt_vld_q || dflt_q != r_q.handler) begin
								r_q.status <= ST_NOT_FOUND;
							end
						end
						CMD_REG_DEF: begin
							r_q.status <= ST_OK;
						end
					endcase
				end
			end
			S_FREE: begin
				cur_q <= head_q[ci];
				prev_q <= NIL;
			end
			S_WALK: ra_q <= cur_q[AW-1:0];
			S_WCHK: begin
				if (rd_p_q >= r_q.prio) begin
					prev_q <= cur_q;
					cur_q <= rd_l_q;
				end
			end
			S_RWALK: begin
				if (cur_q == NIL) begin
					r_q.status <= ST_NOT_FOUND;
				end else begin
					ra_q <= cur_q[AW-1:0];
				end
			end
			S_RCHK: begin
				if (rd_h_q == r_q.handler) begin
					nx_q <= rd_l_q;
				end else begin
					prev_q <= cur_q;
					cur_q <= rd_l_q;
				end
			end
			S_T_START: c_q <= '0;
			S_T_ISSUE: ra_q <= head_q[c_q][AW-1:0];
			S_T_EMIT: begin
				if (room) begin
					c_q <= (c_q == C_LAST) ? '0 : c_q + CW'(1);
				end
			end
			S_L_START: begin
				if (!head_c_nil) begin
					ra_q <= head_q[c_q][AW-1:0];
				end else if (c_q != C_LAST) begin
					c_q <= c_q + CW'(1);
				end
			end
			S_L_H: begin
				cur_h_q <= rd_h_q;
				ra_q <= rd_l_q[AW-1:0];
			end
			S_L_HX: begin
				if (room) begin
					cur_h_q <= rd_h_q;
					ra_q <= rd_l_q[AW-1:0];
				end
			end
			S_L_END: begin
				if (room && c_q != C_LAST) begin
					c_q <= c_q + CW'(1);
				end
			end
			default: begin
				ra_q <= ra_q;
			end
		endcase
		if (em_en) begin
			pend_q <= em;
		end
	end

	// node memories, one shared read address, registered read data
	always_ff @(posedge clk) begin
		if (hw_en) begin
			h_mem[new_q[AW-1:0]] <= r_q.handler;
			p_mem[new_q[AW-1:0]] <= r_q.prio;
		end
		if (lw_en) begin
			l_mem[lw_addr[AW-1:0]] <= lw_data;
		end
		rd_h_q <= h_mem[ra_q];
		rd_p_q <= p_mem[ra_q];
		rd_l_q <= l_vld_q[ra_q] ? l_mem[ra_q] : NW'(ra_q) + NW'(1);
	end

	// result queue
	always_comb begin
		push_en = (em_en && pend_vld_q) || fin_en;
		push_d = pend_q;
		push_d.last = fin_en;
	end

	assign empty = of_cnt_q == 2'd0;
	assign res = of_q[of_rp_q];
	assign pop_en = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			of_wp_q <= 1'b0;
			of_rp_q <= 1'b0;
			of_cnt_q <= 2'd0;
		end else begin
			if (push_en) begin
				of_wp_q <= !of_wp_q;
			end
			if (pop_en) begin
				of_rp_q <= !of_rp_q;
			end
			if (push_en && !pop_en) begin
				of_cnt_q <= of_cnt_q + 2'd1;
			end else if (pop_en && !push_en) begin
				of_cnt_q <= of_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			of_q[of_wp_q] <= push_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/priority_handler_chain_manager_core.sv =====
// Handler chain manager. Commands enter through a two-entry request queue and
// are carried out one at a time by a sequencer that owns the node pool; results
// leave through a two-entry queue. Node handler, priority and link words sit in
// memories behind one shared read address with registered read data, so every
// list step waits for its read data. A command walks the nodes of its chain to
// find its place, then the rebuild: one write per cause table entry, a scan of
// each cause for its chain, one write per linked node and a closing write per
// non-empty cause. Any result write can stall while the result queue is full.
// A rejected command returns its single status result. Link words come up
// valid at reset through per-node valid bits, so no clearing pass is needed.
// The user must write configuration only while no command is in flight; the
// block itself does not enforce this.
`default_nettype none
module priority_handler_chain_manager_core #(
	parameter int CAUSE_COUNT = 16,
	parameter int NODE_COUNT  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  cause,
	input  wire logic [1:0]  priority_req,
	input  wire logic [31:0] handler_addr,
	input  wire logic [31:0] link_word,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       status,
	output logic             write_valid,
	output logic [31:0]      write_addr,
	output logic [31:0]      write_data,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [31:0] cfg_wdata
);
	import phcm_pkg::*;

	logic [31:0] stop_q;
	logic [31:0] tbase_q;
	logic        req_valid;
	req_t        req;
	logic        req_take;
	res_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= STOP_CODE_RST;
			tbase_q <= TABLE_BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_STOP_CODE: stop_q <= cfg_wdata;
				CFG_TABLE_BASE: tbase_q <= cfg_wdata;
			endcase
		end
	end

	phcm_front #(
		.CAUSE_COUNT(CAUSE_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.cause(cause),
		.priority_req(priority_req),
		.handler_addr(handler_addr),
		.link_word(link_word),
		.req_valid(req_valid),
		.req(req),
		.req_take(req_take)
	);

	phcm_back #(
		.CAUSE_COUNT(CAUSE_COUNT),
		.NODE_COUNT(NODE_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.req_take(req_take),
		.stop_code(stop_q),
		.tbl_base(tbase_q),
		.empty(empty),
		.pop(pop),
		.res(res)
	);

	assign status = res.status;
	assign write_valid = res.wv;
	assign write_addr = res.addr;
	assign write_data = res.data;
	assign last = res.last;

endmodule
`default_nettype wire

// ===== sv/phcm_checker.sv =====
`default_nettype none
`include "priority_handler_chain_manager_core_assert.svh"
module phcm_sva (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [2:0]  status,
	input wire logic        write_valid,
	input wire logic [31:0] write_addr,
	input wire logic [31:0] write_data,
	input wire logic        last
);
	import phcm_pkg::*;

	// a rejected command is one result with no write
	`PHCM_ASSERT(a_err_single, !empty && status != ST_OK |-> !write_valid && last)
	`PHCM_ASSERT(a_err_zero, !empty && status != ST_OK |-> write_addr == 32'd0 && write_data == 32'd0)
	`PHCM_NEVER(a_ok_no_write, !empty && status == ST_OK && !write_valid)
	`PHCM_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(write_addr) && $stable(last))

endmodule

bind priority_handler_chain_manager_core phcm_sva u_phcm_sva (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.status(status),
	.write_valid(write_valid),
	.write_addr(write_addr),
	.write_data(write_data),
	.last(last)
);
`default_nettype wire
